FILE: rtl/mobt_pkg.sv
// Package for the multicart outer bank translator: commands, state and result types.
`timescale 1ns / 1ps
package mobt_pkg;

  // Command codes carried by in_cmd
  typedef enum logic [2:0] {
    CMD_REG_WRITE  = 3'd0,
    CMD_CPU_READ   = 3'd1,
    CMD_PRG_XLATE  = 3'd2,
    CMD_CHR_XLATE  = 3'd3,
    CMD_SOFT_RESET = 3'd4
  } cmd_t;

  localparam int unsigned BANK_W = 10;
  localparam int unsigned BYTE_W = 8;

  // Upper three address bits of the 0x6000-0x7FFF register window
  localparam logic [2:0] REG_WINDOW = 3'b011;

  // PRG masks: 128K outer block or 256K outer block
  localparam logic [7:0] PRG_MASK_SMALL = 8'h0F;
  localparam logic [7:0] PRG_MASK_LARGE = 8'h1F;

  // Outer register bit positions
  localparam int unsigned OR_PRG_A17    = 0;
  localparam int unsigned OR_PRG_128K   = 1;
  localparam int unsigned OR_CHR_128K   = 2;
  localparam int unsigned OR_CHR_A18    = 3;
  localparam int unsigned OR_PRG_A18    = 4;
  localparam int unsigned OR_DIP_EN     = 5;
  localparam int unsigned OR_NROM       = 6;
  localparam int unsigned OR_NROM_256   = 7;

  // Architectural state of the block
  typedef struct packed {
    logic [7:0] mode;
    logic [7:0] outer;
    logic [7:0] dip;
  } regs_t;

  // One result word
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [BYTE_W-1:0] read_data;
  } res_t;

endpackage

FILE: rtl/multicart_outer_bank_translator_core.sv
// Top level: outer bank translator with state registers and output skid buffer.
`timescale 1ns / 1ps
// Takes one word per clock while in_stall is low and returns exactly one result
// word for each, in the output register at the accepting edge when out_stall
// is low. The outer and mode registers and DIP counter update at the edge that
// accepts the word, so the next word already sees the new state. Results leave
// through an output register with a one-word skid stage; in_stall comes only
// from the skid stage, so result-side stalls reach the input once it fills;
// while out_stall is low the rate stays one word per cycle. cfg_wr_data sets
// the small-PRG-ROM flag (reset value 1) and should only be written while idle.
module multicart_outer_bank_translator_core
  import mobt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_cmd,
  input  logic [15:0]       in_addr,
  input  logic [7:0]        in_value,
  input  logic [7:0]        in_inner_bank_six,
  input  logic [7:0]        in_inner_bank_seven,
  input  logic              in_wram_writable,
  input  logic [7:0]        in_cart_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BANK_W-1:0] out_bank,
  output logic [BYTE_W-1:0] out_read_data
);

  regs_t regs_r, regs_nxt, regs_calc;
  logic  small_r;
  res_t  res;
  res_t  out_res_r, out_res_nxt;
  res_t  skid_res_r, skid_res_nxt;
  logic  out_vld_r, out_vld_nxt;
  logic  skid_vld_r, skid_vld_nxt;
  logic  in_acc;
  logic  out_acc;

  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_vld_r && !out_stall;

  // Datapath
  mobt_xlate u_xlate (
    .regs             (regs_r),
    .small_prg_rom    (small_r),
    .cmd              (cmd_t'(in_cmd)),
    .addr             (in_addr),
    .value            (in_value),
    .inner_bank_six   (in_inner_bank_six),
    .inner_bank_seven (in_inner_bank_seven),
    .wram_writable    (in_wram_writable),
    .cart_byte        (in_cart_byte),
    .res              (res),
    .regs_nxt         (regs_calc)
  );

  assign regs_nxt = in_acc ? regs_calc : regs_r;

  // State and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r  <= '0;
      small_r <= 1'b1;
    end else begin
      regs_r <= regs_nxt;
      if (cfg_wr_en) begin
        small_r <= cfg_wr_data;
      end
    end
  end

  // Output register and skid stage
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || out_acc) begin
      if (skid_vld_r) begin
        out_res_nxt  = skid_res_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_res_nxt = res;
        out_vld_nxt = in_acc;
      end
    end else if (in_acc) begin
      skid_res_nxt = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_bank      = out_res_r.bank;
  assign out_read_data = out_res_r.read_data;

`ifndef NO_ASSERTIONS
  // Skid stage only holds a word behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word without output word");

  // Soft reset advances the DIP counter by one
  a_dip_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_SOFT_RESET)) |=> (regs_r.dip == 8'($past(regs_r.dip) + 8'd1)))
    else $error("DIP counter did not advance on soft reset");

  // Only writes and soft resets touch the outer register
  a_outer_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc || ((in_cmd != CMD_REG_WRITE) && (in_cmd != CMD_SOFT_RESET)))
      |=> $stable(regs_r.outer))
    else $error("outer register changed without write or soft reset");

  // An accepted word always leaves the output register valid next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_vld_r)
    else $error("accepted word produced no result");
`endif

endmodule

FILE: rtl/mobt_xlate.sv
// Translate datapath: result word and next register state for one input word.
`timescale 1ns / 1ps
module mobt_xlate
  import mobt_pkg::*;
(
  input  regs_t       regs,
  input  logic        small_prg_rom,
  input  cmd_t        cmd,
  input  logic [15:0] addr,
  input  logic [7:0]  value,
  input  logic [7:0]  inner_bank_six,
  input  logic [7:0]  inner_bank_seven,
  input  logic        wram_writable,
  input  logic [7:0]  cart_byte,
  output res_t        res,
  output regs_t       regs_nxt
);

  logic [7:0] prg_mask;
  logic [7:0] prg_base;
  logic [7:0] prg_inner;
  logic [7:0] prg_bank;
  logic [9:0] chr_bank;
  logic       dip_sel;
  logic       reg_hit;

  // PRG: outer base over the inner 8K bank, NROM modes take banks 6/7
  always_comb begin
    prg_mask = regs.outer[OR_PRG_128K] ? PRG_MASK_SMALL : PRG_MASK_LARGE;
    prg_base = {1'b0, regs.outer[OR_DIP_EN], regs.outer[OR_PRG_A18],
                regs.outer[OR_PRG_A17], 4'b0000};
    if (regs.outer[OR_NROM]) begin
      prg_inner = addr[13] ? inner_bank_seven : inner_bank_six;
      if (regs.outer[OR_NROM_256]) begin
        prg_inner[1] = addr[14];
      end
    end else begin
      prg_inner = value;
    end
    prg_bank = (prg_base & ~prg_mask) | (prg_inner & prg_mask);
  end

  // CHR: bit 7 comes from the outer base in 128K mode
  assign chr_bank = {regs.outer[OR_DIP_EN], regs.outer[OR_CHR_A18],
                     regs.outer[OR_CHR_128K] ? regs.outer[OR_PRG_A17] : value[7],
                     value[6:0]};

  assign dip_sel = addr[15] &&
                   (regs.mode[0] || (regs.outer[OR_DIP_EN] && small_prg_rom));
  assign reg_hit = wram_writable && (addr[15:13] == REG_WINDOW);

  // Result and state update per command
  always_comb begin
    res      = '0;
    regs_nxt = regs;
    case (cmd)
      CMD_REG_WRITE: begin
        if (reg_hit) begin
          if (addr[0]) begin
            regs_nxt.outer = value;
          end else begin
            regs_nxt.mode = value;
            if (!value[0] && small_prg_rom) begin
              regs_nxt.outer[OR_DIP_EN] = 1'b0;
            end
          end
        end
      end
      CMD_CPU_READ: begin
        res.read_data = dip_sel ? regs.dip : cart_byte;
      end
      CMD_PRG_XLATE: begin
        res.bank = {2'b00, prg_bank};
      end
      CMD_CHR_XLATE: begin
        res.bank = chr_bank;
      end
      CMD_SOFT_RESET: begin
        regs_nxt.mode  = '0;
        regs_nxt.outer = '0;
        regs_nxt.dip   = regs.dip + 8'd1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

FILE: tb/multicart_outer_bank_translator_core_tb.sv
// Self-checking testbench for the multicart outer bank translator core.
`timescale 1ns / 1ps
module multicart_outer_bank_translator_core_tb;
  import mobt_pkg::*;

  // Command codes outside the defined set: the block must ignore them
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Register addresses in the 0x6000 window; address bit 0 picks the register
  localparam logic [15:0] MODE_REG_ADDR  = 16'h6000;
  localparam logic [15:0] OUTER_REG_ADDR = 16'h6001;
  localparam logic [15:0] MODE_REG_TOP   = 16'h7FFE;
  localparam logic [15:0] OUTER_REG_TOP  = 16'h7FFF;

  // Mode register bit that forces DIP reads
  localparam int unsigned MODE_DIP_FORCE = 0;

  // One input word as the sender sees it
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  value;
    logic [7:0]  six;
    logic [7:0]  seven;
    logic        wram;
    logic [7:0]  cart;
  } access_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_cmd;
  logic [15:0]       in_addr;
  logic [7:0]        in_value;
  logic [7:0]        in_inner_bank_six;
  logic [7:0]        in_inner_bank_seven;
  logic              in_wram_writable;
  logic [7:0]        in_cart_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BANK_W-1:0] out_bank;
  logic [BYTE_W-1:0] out_read_data;

  // Mapper state tracked by the testbench
  logic       tb_small_rom = 1'b1;
  logic [7:0] tb_mode      = '0;
  logic [7:0] tb_outer     = '0;
  logic [7:0] tb_dip       = '0;

  res_t pending_results[$];

  int unsigned mismatch_count      = 0;
  int unsigned words_sent          = 0;
  int unsigned results_checked     = 0;
  int unsigned soft_resets_sent    = 0;
  int unsigned input_stall_cycles  = 0;
  int unsigned flag_writes         = 0;
  int unsigned in_idle_pct         = 25;
  int unsigned out_idle_pct        = 25;
  int unsigned hold_off_cycles     = 0;

  multicart_outer_bank_translator_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_addr             (in_addr),
    .in_value            (in_value),
    .in_inner_bank_six   (in_inner_bank_six),
    .in_inner_bank_seven (in_inner_bank_seven),
    .in_wram_writable    (in_wram_writable),
    .in_cart_byte        (in_cart_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_bank            (out_bank),
    .out_read_data       (out_read_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Apply one word to the tracked state and work out its result
  function automatic res_t apply_access(input access_t a);
    res_t       r;
    logic [9:0] mask;
    logic [9:0] base;
    logic [9:0] inner;
    r = '0;
    case (a.cmd)
      CMD_REG_WRITE: begin
        if (a.wram && a.addr[15:13] == REG_WINDOW) begin
          if (a.addr[0]) begin
            tb_outer = a.value;
          end else begin
            tb_mode = a.value;
            // even mode write drops the DIP enable on small ROMs
            if (!a.value[0] && tb_small_rom) tb_outer[OR_DIP_EN] = 1'b0;
          end
        end
      end
      CMD_CPU_READ: begin
        if (a.addr[15] &&
            (tb_mode[MODE_DIP_FORCE] || (tb_outer[OR_DIP_EN] && tb_small_rom)))
          r.read_data = tb_dip;
        else
          r.read_data = a.cart;
      end
      CMD_PRG_XLATE: begin
        mask = tb_outer[OR_PRG_128K] ? {2'b00, PRG_MASK_SMALL} : {2'b00, PRG_MASK_LARGE};
        base = {3'b000, tb_outer[OR_DIP_EN], tb_outer[OR_PRG_A18], tb_outer[OR_PRG_A17],
                4'b0000};
        if (tb_outer[OR_NROM]) begin
          // odd slots take bank 7, even slots bank 6
          inner = {2'b00, a.addr[13] ? a.seven : a.six};
          if (tb_outer[OR_NROM_256]) inner[1] = a.addr[14];
        end else begin
          inner = {2'b00, a.value};
        end
        r.bank = (base & ~mask) | (inner & mask);
      end
      CMD_CHR_XLATE: begin
        mask = tb_outer[OR_CHR_128K] ? 10'h07F : 10'h0FF;
        base = {tb_outer[OR_DIP_EN], tb_outer[OR_CHR_A18], tb_outer[OR_PRG_A17], 7'b0};
        r.bank = (base & ~mask) | ({2'b00, a.value} & mask);
      end
      CMD_SOFT_RESET: begin
        tb_mode  = '0;
        tb_outer = '0;
        tb_dip   = tb_dip + 8'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random word; register writes are weighted toward ones that actually land
  function automatic access_t rand_access();
    access_t     a;
    int unsigned pick;
    a.addr  = 16'($urandom);
    a.value = 8'($urandom);
    a.six   = 8'($urandom);
    a.seven = 8'($urandom);
    a.wram  = 1'($urandom);
    a.cart  = 8'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 22) begin
      a.cmd = CMD_REG_WRITE;
      if ($urandom_range(0, 99) < 85) a.addr = {REG_WINDOW, 13'($urandom)};
      a.wram = ($urandom_range(0, 9) != 0);
    end else if (pick < 40) begin
      a.cmd = CMD_CPU_READ;
    end else if (pick < 65) begin
      a.cmd = CMD_PRG_XLATE;
    end else if (pick < 88) begin
      a.cmd = CMD_CHR_XLATE;
    end else if (pick < 94) begin
      a.cmd = CMD_SOFT_RESET;
    end else begin
      case ($urandom_range(0, 2))
        0:       a.cmd = CMD_SPARE_5;
        1:       a.cmd = CMD_SPARE_6;
        default: a.cmd = CMD_SPARE_7;
      endcase
    end
    return a;
  endfunction

  // Offer one word, wait for the handshake, then record what should come back
  task automatic send_word(input access_t a);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cmd              <= a.cmd;
    in_addr             <= a.addr;
    in_value            <= a.value;
    in_inner_bank_six   <= a.six;
    in_inner_bank_seven <= a.seven;
    in_wram_writable    <= a.wram;
    in_cart_byte        <= a.cart;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_access(a));
    words_sent++;
    if (a.cmd == CMD_SOFT_RESET) soft_resets_sent++;
  endtask

  task automatic send_fields(input logic [2:0] cmd, input logic [15:0] addr,
                             input logic [7:0] value, input logic [7:0] six = 8'h00,
                             input logic [7:0] seven = 8'h00, input logic wram = 1'b1,
                             input logic [7:0] cart = 8'h00);
    send_word('{cmd: cmd, addr: addr, value: value, six: six, seven: seven, wram: wram,
                cart: cart});
  endtask

  // Sender holds off until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Only called with the pipeline empty
  task automatic write_small_rom(input logic flag);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= flag;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    tb_small_rom = flag;
    flag_writes++;
  endtask

  // Reset values, ignored writes, both NROM modes, DIP clear and soft reset
  task automatic test_directed_cases();
    send_fields(CMD_CPU_READ, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b1, 8'hA5);
    send_fields(CMD_PRG_XLATE, 16'hE000, 8'hFF);
    send_fields(CMD_CHR_XLATE, 16'h0000, 8'hFF);
    send_fields(CMD_SPARE_5, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    send_fields(CMD_SPARE_6, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    send_fields(CMD_SPARE_7, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    // writes outside the window or with WRAM locked must not land
    send_fields(CMD_REG_WRITE, 16'h5FFF, 8'hFF);
    send_fields(CMD_REG_WRITE, 16'h8001, 8'hFF);
    send_fields(CMD_REG_WRITE, OUTER_REG_ADDR, 8'hFF, 8'h00, 8'h00, 1'b0);
    send_fields(CMD_PRG_XLATE, 16'h8000, 8'hFF);
    // NROM-256 with every outer bit set, all four slots
    send_fields(CMD_REG_WRITE, OUTER_REG_TOP, 8'hFF);
    send_fields(CMD_PRG_XLATE, 16'h8000, 8'h00, 8'h55, 8'hAA);
    send_fields(CMD_PRG_XLATE, 16'hA000, 8'h00, 8'h55, 8'hAA);
    send_fields(CMD_PRG_XLATE, 16'hC000, 8'h00, 8'h55, 8'hAA);
    send_fields(CMD_PRG_XLATE, 16'hE000, 8'h00, 8'h55, 8'hAA);
    send_fields(CMD_CHR_XLATE, 16'h0000, 8'h00);
    send_fields(CMD_CPU_READ, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h3C);
    send_fields(CMD_CPU_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, 8'h3C);
    // even mode write clears the DIP enable
    send_fields(CMD_REG_WRITE, MODE_REG_ADDR, 8'h00);
    send_fields(CMD_CPU_READ, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b1, 8'h96);
    // NROM-128
    send_fields(CMD_REG_WRITE, OUTER_REG_ADDR, 8'h40);
    send_fields(CMD_PRG_XLATE, 16'hA000, 8'hFF, 8'h13, 8'hEC);
    send_fields(CMD_PRG_XLATE, 16'hC000, 8'hFF, 8'h13, 8'hEC);
    // forced DIP read, then soft reset
    send_fields(CMD_REG_WRITE, MODE_REG_TOP, 8'h01);
    send_fields(CMD_CPU_READ, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b1, 8'h5A);
    send_fields(CMD_SOFT_RESET, 16'h0000, 8'h00);
    send_fields(CMD_CPU_READ, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b1, 8'h5A);
  endtask

  // DIP enable and the clearing write only matter on small ROMs
  task automatic test_small_rom_flag();
    drain_results();
    write_small_rom(1'b0);
    send_fields(CMD_REG_WRITE, OUTER_REG_ADDR, 8'h20);
    send_fields(CMD_CPU_READ, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b1, 8'hC3);
    send_fields(CMD_REG_WRITE, MODE_REG_ADDR, 8'h00);
    send_fields(CMD_CHR_XLATE, 16'h0000, 8'h81);
    drain_results();
    write_small_rom(1'b1);
    send_fields(CMD_CPU_READ, 16'hC000, 8'h00, 8'h00, 8'h00, 1'b1, 8'hC3);
    send_fields(CMD_REG_WRITE, MODE_REG_ADDR, 8'h00);
    send_fields(CMD_CHR_XLATE, 16'h0000, 8'h81);
  endtask

  task automatic test_random_traffic(input int unsigned count, input logic flag,
                                     input int unsigned in_pct, input int unsigned out_pct);
    drain_results();
    write_small_rom(flag);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (count) send_word(rand_access());
  endtask

  // Long result-side stall while the sender keeps pushing: input must back up
  task automatic test_hold_off();
    in_idle_pct     = 0;
    hold_off_cycles = 60;
    repeat (40) send_word(rand_access());
    in_idle_pct = 25;
    drain_results();
  endtask

  // Walk the DIP counter through its 8-bit wrap, reading it along the way
  task automatic test_dip_wrap();
    for (int i = 0; i < 260; i++) begin
      send_fields(CMD_SOFT_RESET, 16'($urandom), 8'($urandom));
      if (i % 32 == 31 || i >= 254) begin
        send_fields(CMD_REG_WRITE, MODE_REG_ADDR, 8'h01);
        send_fields(CMD_CPU_READ, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'($urandom));
      end
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        out_stall <= 1'b0;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result word against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word bank=%0h data=%0h",
                                  out_bank, out_read_data));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_bank !== want.bank)
          report_mismatch($sformatf("bank got %0h want %0h", out_bank, want.bank));
        if (out_read_data !== want.read_data)
          report_mismatch($sformatf("read_data got %0h want %0h",
                                    out_read_data, want.read_data));
      end
    end
  end

  // Main sequence
  initial begin
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= 1'b0;
    in_valid            <= 1'b0;
    in_cmd              <= CMD_REG_WRITE;
    in_addr             <= '0;
    in_value            <= '0;
    in_inner_bank_six   <= '0;
    in_inner_bank_seven <= '0;
    in_wram_writable    <= 1'b0;
    in_cart_byte        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_small_rom_flag();
    test_random_traffic(110, 1'b1, 30, 30);
    test_hold_off();
    test_dip_wrap();
    test_random_traffic(60, 1'b0, 20, 45);
    test_random_traffic(60, 1'b1, 45, 10);
    // closing stretch with no idling on either side
    test_random_traffic(60, 1'b1, 0, 0);

    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Sent %0d words (%0d soft resets), checked %0d results, %0d flag writes",
             words_sent, soft_resets_sent, results_checked, flag_writes);
    $display("Input held off for %0d cycles; DIP counter ended at %0d",
             input_stall_cycles, tb_dip);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
